@@ rtl/core/lsc_pkg.sv @@
// Package for the lidar scan clustering block: types, constants and helper functions.
`default_nettype none
package lsc_pkg;

  localparam int MAX_POINTS         = 512;
  localparam int MAX_CLUSTERS       = 32;
  localparam int MAX_CLUSTER_POINTS = 64;

  localparam int PT_AW = $clog2(MAX_POINTS);
  localparam int CL_AW = $clog2(MAX_CLUSTERS);

  localparam logic [15:0] FULL_TURN    = 16'd23040;
  localparam logic [15:0] QUARTER_TURN = 16'd5760;
  localparam logic [15:0] HALF_TURN    = 16'd11520;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd17280;
  localparam logic signed [19:0] CORDIC_X0 = 20'sd19898;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_FINISH = 2'd1;
  localparam cmd_t CMD_FETCH  = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SUMMARY = 2'd0;
  localparam kind_t KIND_POINT   = 2'd1;
  localparam kind_t KIND_NONE    = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_GAP_THRESHOLD = 2'd0;
  localparam reg_idx_t REG_MIN_POINTS    = 2'd1;
  localparam reg_idx_t REG_MAX_RANGE     = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LMOD, ST_LQUAD, ST_LROT, ST_LSAT, ST_LMULX, ST_LWRX, ST_LMULY, ST_LWRY,
    ST_FINIT, ST_FPREV, ST_FRD, ST_FDIFF, ST_FSQX, ST_FSQY, ST_FCMP, ST_FBRK,
    ST_FW0, ST_FW1, ST_FW2, ST_FW3, ST_FDONE, ST_GA, ST_GB, ST_GC, ST_GD
  } state_t;

  function automatic logic signed [21:0] cordic_atan(input logic [3:0] k);
    logic signed [21:0] v;
    case (k)
      4'd0:    v = 22'sd737280;
      4'd1:    v = 22'sd435242;
      4'd2:    v = 22'sd229970;
      4'd3:    v = 22'sd116736;
      4'd4:    v = 22'sd58595;
      4'd5:    v = 22'sd29326;
      4'd6:    v = 22'sd14667;
      4'd7:    v = 22'sd7334;
      4'd8:    v = 22'sd3667;
      4'd9:    v = 22'sd1833;
      4'd10:   v = 22'sd917;
      4'd11:   v = 22'sd458;
      4'd12:   v = 22'sd229;
      4'd13:   v = 22'sd115;
      4'd14:   v = 22'sd57;
      4'd15:   v = 22'sd29;
      default: v = 22'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat_q15(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sd32767;
    else if (v < -20'sd32767) r = -16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) r = 24'sh7FFFFF;
    else if (v < -27'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lidar_scan_clustering.sv @@
// Lidar scan clustering: CORDIC point conversion, breakpoint segmentation and point fetch.
// Load: a kept reading runs 16 CORDIC steps on one rotator; a dropped reading is not stored.
// Finish: each stored point passes through the shared multiplier for the gap test.
// Fetch: each point is a run table read then a store read; an empty fetch answers from idle.
// A new word is taken only when idle and the previous result has been taken.
// rst is synchronous; it clears control state and loads register defaults; stores stay unset.
`default_nettype none
module lidar_scan_clustering (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire lsc_pkg::reg_idx_t cfg_index,
  input  wire [15:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire lsc_pkg::cmd_t  command,
  input  wire [14:0]          angle,
  input  wire [15:0]          dist_mm,
  input  wire signed [23:0]   pose_x,
  input  wire signed [23:0]   pose_y,
  input  wire [14:0]          pose_heading,
  output logic                out_valid,
  input  wire                 out_stall,
  output lsc_pkg::kind_t      kind,
  output logic [5:0]          cluster_total,
  output logic [4:0]          cluster_number,
  output logic signed [23:0]  world_x,
  output logic signed [23:0]  world_y,
  output logic                cluster_end,
  output logic                scan_end
);
  import lsc_pkg::*;

  state_t state, state_next;

  logic [15:0] gap_threshold_mm, max_range_mm;
  logic [9:0]  min_points;

  logic [PT_AW:0]   point_total;
  logic [CL_AW:0]   clusters_found;
  logic [6:0]       wrap_prefix;
  logic [CL_AW:0]   fetch_cluster;
  logic [6:0]       fetch_point;

  logic [23:0] store_x [MAX_POINTS];
  logic [23:0] store_y [MAX_POINTS];
  logic [PT_AW-1:0] run_start [MAX_CLUSTERS];
  logic [6:0]       run_length [MAX_CLUSTERS];

  logic accept;
  logic [PT_AW-1:0] rd_addr;
  logic             rd_en;
  logic signed [23:0] rd_x, rd_y;
  logic [CL_AW-1:0] rt_addr;
  logic [PT_AW-1:0] rt_rs;
  logic [6:0]       rt_rl;

  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;
  logic signed [51:0] prod;

  logic [15:0] dist_q;
  logic signed [23:0] px, py;
  logic [15:0] ang;
  logic [1:0]  quad;
  logic signed [19:0] cx, cy;
  logic signed [21:0] cz;
  logic [3:0]  step;
  logic signed [15:0] cos_v, sin_v;
  logic signed [19:0] xs, ys;
  logic signed [33:0] rnd;
  logic signed [26:0] wsum;

  logic [31:0] thr2;
  logic [PT_AW:0] idx_i, run_st;
  logic signed [23:0] prev_x, prev_y;
  logic signed [24:0] dx, dy;
  logic [49:0] acc, sq;
  logic brk;
  logic wrap_mode;
  logic [PT_AW:0] run_len;
  logic [PT_AW-1:0] rs_last, rs_first;
  logic [6:0] rl_last, rl_first;
  logic [PT_AW-1:0] rs_f;
  logic [6:0] rl_f;
  logic [7:0] fetch_len;
  logic [PT_AW-1:0] fetch_idx;
  logic pend_cend, pend_send;
  logic [CL_AW-1:0] pend_cnum;

  assign accept = in_valid && !in_stall;
  assign mul_p = mul_a * mul_b;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign brk = ({1'b0, acc} + {1'b0, sq}) > {19'd0, thr2};
  assign run_len = idx_i - run_st;
  assign rnd = prod[33:0] + 34'sd16384;
  assign fetch_len = {1'b0, rl_f} + ((fetch_cluster == '0) ? {1'b0, wrap_prefix} : 8'd0);

  always_comb begin
    if (fetch_cluster == '0 && fetch_point < wrap_prefix)
      fetch_idx = rt_rs + PT_AW'(fetch_point);
    else if (fetch_cluster == '0)
      fetch_idx = rs_f + PT_AW'(fetch_point) - PT_AW'(wrap_prefix);
    else
      fetch_idx = rs_f + PT_AW'(fetch_point);
  end

  always_comb begin
    if (state == ST_LWRX)
      wsum = 27'(px) + 27'(rnd >>> 15);
    else
      wsum = 27'(py) + 27'(rnd >>> 15);
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_LOAD: begin
              if (dist_mm != 16'd0 && dist_mm <= max_range_mm &&
                  point_total < (PT_AW+1)'(MAX_POINTS))
                state_next = ST_LMOD;
            end
            CMD_FINISH: state_next = ST_FINIT;
            CMD_FETCH: begin
              if (fetch_cluster < clusters_found) state_next = ST_GA;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LMOD:  if (ang < FULL_TURN) state_next = ST_LQUAD;
      ST_LQUAD: state_next = ST_LROT;
      ST_LROT:  if (step == 4'd15) state_next = ST_LSAT;
      ST_LSAT:  state_next = ST_LMULX;
      ST_LMULX: state_next = ST_LWRX;
      ST_LWRX:  state_next = ST_LMULY;
      ST_LMULY: state_next = ST_LWRY;
      ST_LWRY:  state_next = ST_IDLE;
      ST_FINIT: state_next = (point_total == '0) ? ST_FW0 : ST_FPREV;
      ST_FPREV: state_next = ST_FRD;
      ST_FRD:   state_next = (idx_i == point_total) ? ST_FBRK : ST_FDIFF;
      ST_FDIFF: state_next = ST_FSQX;
      ST_FSQX:  state_next = ST_FSQY;
      ST_FSQY:  state_next = ST_FCMP;
      ST_FCMP: begin
        if (wrap_mode) state_next = ST_FDONE;
        else if (brk) state_next = ST_FBRK;
        else state_next = ST_FRD;
      end
      ST_FBRK:  state_next = (idx_i == point_total) ? ST_FW0 : ST_FRD;
      ST_FW0:   state_next = (clusters_found >= (CL_AW+1)'(2)) ? ST_FW1 : ST_FDONE;
      ST_FW1:   state_next = ST_FW2;
      ST_FW2:   state_next = ST_FW3;
      ST_FW3:   state_next = ST_FDIFF;
      ST_FDONE: state_next = ST_IDLE;
      ST_GA:    state_next = ST_GB;
      ST_GB:    state_next = ST_GC;
      ST_GC:    state_next = ST_GD;
      ST_GD:    state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs: handshake, multiplier operands, memory read ports
  always_comb begin
    in_stall = (state != ST_IDLE) || out_valid;
    mul_a = '0;
    mul_b = '0;
    rd_en = 1'b0;
    rd_addr = '0;
    rt_addr = '0;
    case (state)
      ST_LMULX: begin
        mul_a = 26'($signed({1'b0, dist_q}));
        mul_b = 26'(cos_v);
      end
      ST_LMULY: begin
        mul_a = 26'($signed({1'b0, dist_q}));
        mul_b = 26'(sin_v);
      end
      ST_FINIT: begin
        mul_a = 26'($signed({1'b0, gap_threshold_mm}));
        mul_b = 26'($signed({1'b0, gap_threshold_mm}));
        rd_en = 1'b1;
      end
      ST_FRD: begin
        rd_en = 1'b1;
        rd_addr = idx_i[PT_AW-1:0];
      end
      ST_FSQX: begin
        mul_a = 26'(dx);
        mul_b = 26'(dx);
      end
      ST_FSQY: begin
        mul_a = 26'(dy);
        mul_b = 26'(dy);
      end
      ST_FW0: rt_addr = CL_AW'(clusters_found - (CL_AW+1)'(1));
      ST_FW2: begin
        rd_en = 1'b1;
        rd_addr = rs_last + PT_AW'(rl_last) - PT_AW'(1);
      end
      ST_FW3: begin
        rd_en = 1'b1;
        rd_addr = rs_first;
      end
      ST_GA: rt_addr = fetch_cluster[CL_AW-1:0];
      ST_GB: rt_addr = clusters_found[CL_AW-1:0];
      ST_GC: begin
        rd_en = 1'b1;
        rd_addr = fetch_idx;
      end
      default: ;
    endcase
  end

  // Point store and run table
  always_ff @(posedge clk) begin
    if (state == ST_LWRX) store_x[point_total[PT_AW-1:0]] <= sat24(wsum);
    if (state == ST_LWRY) store_y[point_total[PT_AW-1:0]] <= sat24(wsum);
    if (rd_en) begin
      rd_x <= store_x[rd_addr];
      rd_y <= store_y[rd_addr];
    end
    if (state == ST_FBRK && {1'b0, run_len} >= {1'b0, min_points} &&
        clusters_found < (CL_AW+1)'(MAX_CLUSTERS)) begin
      run_start[clusters_found[CL_AW-1:0]] <= run_st[PT_AW-1:0];
      run_length[clusters_found[CL_AW-1:0]] <=
        (run_len > (PT_AW+1)'(MAX_CLUSTER_POINTS)) ? 7'(MAX_CLUSTER_POINTS) : run_len[6:0];
    end
    rt_rs <= run_start[rt_addr];
    rt_rl <= run_length[rt_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dist_q <= dist_mm;
        px <= pose_x;
        py <= pose_y;
        ang <= {1'b0, angle} + {1'b0, pose_heading};
      end
      ST_LMOD: if (ang >= FULL_TURN) ang <= ang - FULL_TURN;
      ST_LQUAD: begin
        cx <= CORDIC_X0;
        cy <= '0;
        step <= '0;
        if (ang >= THREE_QUARTER_TURN) begin
          quad <= 2'd3;
          cz <= $signed({1'b0, 13'(ang - THREE_QUARTER_TURN), 8'd0});
        end else if (ang >= HALF_TURN) begin
          quad <= 2'd2;
          cz <= $signed({1'b0, 13'(ang - HALF_TURN), 8'd0});
        end else if (ang >= QUARTER_TURN) begin
          quad <= 2'd1;
          cz <= $signed({1'b0, 13'(ang - QUARTER_TURN), 8'd0});
        end else begin
          quad <= 2'd0;
          cz <= $signed({1'b0, 13'(ang), 8'd0});
        end
      end
      ST_LROT: begin
        step <= step + 4'd1;
        if (!cz[21]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - cordic_atan(step);
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + cordic_atan(step);
        end
      end
      ST_LSAT: begin
        case (quad)
          2'd0: begin cos_v <= sat_q15(cx);  sin_v <= sat_q15(cy);  end
          2'd1: begin cos_v <= -sat_q15(cy); sin_v <= sat_q15(cx);  end
          2'd2: begin cos_v <= -sat_q15(cx); sin_v <= -sat_q15(cy); end
          default: begin cos_v <= sat_q15(cy); sin_v <= -sat_q15(cx); end
        endcase
      end
      ST_LMULX, ST_LMULY: prod <= mul_p;
      ST_FINIT: begin
        thr2 <= mul_p[31:0];
        idx_i <= (PT_AW+1)'(1);
        run_st <= '0;
        wrap_mode <= 1'b0;
      end
      ST_FPREV: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
      end
      ST_FDIFF: begin
        dx <= 25'(rd_x) - 25'(prev_x);
        dy <= 25'(rd_y) - 25'(prev_y);
        prev_x <= rd_x;
        prev_y <= rd_y;
      end
      ST_FSQX: acc <= mul_p[49:0];
      ST_FSQY: sq <= mul_p[49:0];
      ST_FCMP: if (!wrap_mode && !brk) idx_i <= idx_i + (PT_AW+1)'(1);
      ST_FBRK: begin
        run_st <= idx_i;
        idx_i <= idx_i + (PT_AW+1)'(1);
      end
      ST_FW1: begin
        rs_last <= rt_rs;
        rl_last <= rt_rl;
      end
      ST_FW2: begin
        rs_first <= rt_rs;
        rl_first <= rt_rl;
        wrap_mode <= 1'b1;
      end
      ST_FW3: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
      end
      ST_GB: begin
        rs_f <= rt_rs;
        rl_f <= rt_rl;
      end
      ST_GC: begin
        pend_cnum <= fetch_cluster[CL_AW-1:0];
        pend_cend <= ({1'b0, fetch_point} + 8'd1) >= fetch_len;
        pend_send <= (fetch_cluster + (CL_AW+1)'(1)) == clusters_found;
      end
      default: ;
    endcase
  end

  // Control state, registers and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gap_threshold_mm <= 16'd100;
      min_points <= 10'd3;
      max_range_mm <= 16'd12000;
      point_total <= '0;
      clusters_found <= '0;
      wrap_prefix <= '0;
      fetch_cluster <= '0;
      fetch_point <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_GAP_THRESHOLD: gap_threshold_mm <= cfg_data;
          REG_MIN_POINTS:    min_points <= cfg_data[9:0];
          REG_MAX_RANGE:     max_range_mm <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && command == CMD_FETCH && fetch_cluster >= clusters_found) begin
            out_valid <= 1'b1;
            kind <= KIND_NONE;
            cluster_total <= '0;
            cluster_number <= '0;
            world_x <= '0;
            world_y <= '0;
            cluster_end <= 1'b0;
            scan_end <= 1'b0;
          end
        end
        ST_LWRY: point_total <= point_total + (PT_AW+1)'(1);
        ST_FINIT: begin
          clusters_found <= '0;
          wrap_prefix <= '0;
        end
        ST_FBRK: begin
          if ({1'b0, run_len} >= {1'b0, min_points} &&
              clusters_found < (CL_AW+1)'(MAX_CLUSTERS))
            clusters_found <= clusters_found + (CL_AW+1)'(1);
        end
        ST_FCMP: begin
          // merge across the wrap when the scan closes on itself
          if (wrap_mode && !brk) begin
            if ({1'b0, rl_last} + {1'b0, rl_first} <= 8'(MAX_CLUSTER_POINTS))
              wrap_prefix <= rl_last;
            clusters_found <= clusters_found - (CL_AW+1)'(1);
          end
        end
        ST_FDONE: begin
          point_total <= '0;
          fetch_cluster <= '0;
          fetch_point <= '0;
          out_valid <= 1'b1;
          kind <= KIND_SUMMARY;
          cluster_total <= 6'(clusters_found);
          cluster_number <= '0;
          world_x <= '0;
          world_y <= '0;
          cluster_end <= 1'b0;
          scan_end <= 1'b0;
        end
        ST_GC: begin
          if (({1'b0, fetch_point} + 8'd1) >= fetch_len) begin
            fetch_cluster <= fetch_cluster + (CL_AW+1)'(1);
            fetch_point <= '0;
          end else begin
            fetch_point <= fetch_point + 7'd1;
          end
        end
        ST_GD: begin
          out_valid <= 1'b1;
          kind <= KIND_POINT;
          cluster_total <= '0;
          cluster_number <= 5'(pend_cnum);
          world_x <= rd_x;
          world_y <= rd_y;
          cluster_end <= pend_cend;
          scan_end <= pend_cend && pend_send;
        end
        default: ;
      endcase
    end
  end

  a_pt_bound: assert property (@(posedge clk) disable iff (rst)
    point_total <= (PT_AW+1)'(MAX_POINTS))
    else $error("point count above store size");
  a_cl_bound: assert property (@(posedge clk) disable iff (rst)
    clusters_found <= (CL_AW+1)'(MAX_CLUSTERS))
    else $error("cluster count above limit");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_summary: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FDONE) |=> (out_valid && kind == KIND_SUMMARY))
    else $error("finish summary missing");
  a_point: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GD) |=> (out_valid && kind == KIND_POINT))
    else $error("fetched point missing");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for lidar_scan_clustering: random scans checked against a built-in predictor.
`timescale 1ns / 100ps
module testbench;
  import lsc_pkg::*;

  localparam cmd_t CMD_IGNORED = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TARGET_ITEMS = 1800;
  localparam int ATAN_TABLE [16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
                                     7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  typedef struct {
    cmd_t        cmd;
    logic [14:0] ang;
    logic [15:0] dmm;
    logic [23:0] px;
    logic [23:0] py;
    logic [14:0] hd;
  } reading_t;

  typedef struct {
    kind_t       kind;
    logic [5:0]  total;
    logic [4:0]  number;
    logic [23:0] wx;
    logic [23:0] wy;
    logic        cend;
    logic        send;
  } answer_t;

  logic clk, rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_stall;
  cmd_t command;
  logic [14:0] angle, pose_heading;
  logic [15:0] dist_mm;
  logic signed [23:0] pose_x, pose_y;
  logic out_valid, out_stall;
  kind_t kind;
  logic [5:0] cluster_total;
  logic [4:0] cluster_number;
  logic signed [23:0] world_x, world_y;
  logic cluster_end, scan_end;

  lidar_scan_clustering uut (.*);

  // predictor state
  int unsigned gap_mm, min_run, range_mm;
  longint pts_x [MAX_POINTS];
  longint pts_y [MAX_POINTS];
  int unsigned stored, wrap_len, clusters, fetch_cl, fetch_pt;
  int unsigned seg_start [MAX_CLUSTERS];
  int unsigned seg_len [MAX_CLUSTERS];

  reading_t pending [$];
  answer_t awaited [$];
  reading_t cur;
  int burst_left, gap_left, items_made;
  int hold_left, stall_phase, stall_mode;
  logic hold_req, hold_done;
  bit failed;
  int cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat24v(longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  task automatic rotate(input int unsigned a, output longint c, output longint s);
    longint x, y, z, xs, ys, cx, sy;
    x = 19898;
    y = 0;
    z = longint'(a % 5760) << 8;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TABLE[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TABLE[i];
      end
    end
    cx = x > 32767 ? 32767 : (x < -32767 ? -32767 : x);
    sy = y > 32767 ? 32767 : (y < -32767 ? -32767 : y);
    case ((a / 5760) % 4)
      0: begin c = cx; s = sy; end
      1: begin c = -sy; s = cx; end
      2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endtask

  function automatic longint gap2(int unsigned a, int unsigned b);
    longint dx, dy;
    dx = pts_x[a] - pts_x[b];
    dy = pts_y[a] - pts_y[b];
    return dx * dx + dy * dy;
  endfunction

  task automatic segment_scan();
    int unsigned start, len, last, tail;
    longint thr2;
    start = 0;
    thr2 = longint'(gap_mm) * gap_mm;
    clusters = 0;
    wrap_len = 0;
    for (int unsigned i = 1; i <= stored; i++) begin
      if (i == stored || gap2(i, i - 1) > thr2) begin
        len = i - start;
        if (len >= min_run && clusters < MAX_CLUSTERS) begin
          seg_start[clusters] = start;
          seg_len[clusters] = len > MAX_CLUSTER_POINTS ? MAX_CLUSTER_POINTS : len;
          clusters++;
        end
        start = i;
      end
    end
    if (clusters >= 2) begin
      last = clusters - 1;
      tail = seg_start[last] + seg_len[last] - 1;
      if (gap2(seg_start[0], tail) <= thr2) begin
        if (seg_len[last] + seg_len[0] <= MAX_CLUSTER_POINTS) wrap_len = seg_len[last];
        clusters--;
      end
    end
    stored = 0;
    fetch_cl = 0;
    fetch_pt = 0;
  endtask

  task automatic predict_answer(input reading_t r);
    answer_t ans;
    longint c, s;
    int unsigned len, idx;
    ans = '{default: '0};
    case (r.cmd)
      CMD_LOAD: begin
        if (r.dmm != 0 && r.dmm <= range_mm && stored < MAX_POINTS) begin
          rotate((int'(r.ang) + int'(r.hd)) % 23040, c, s);
          pts_x[stored] = sat24v(longint'($signed(r.px)) +
                                 ((longint'(r.dmm) * c + 16384) >>> 15));
          pts_y[stored] = sat24v(longint'($signed(r.py)) +
                                 ((longint'(r.dmm) * s + 16384) >>> 15));
          stored++;
        end
      end
      CMD_FINISH: begin
        segment_scan();
        ans.kind = KIND_SUMMARY;
        ans.total = 6'(clusters);
        awaited.push_back(ans);
      end
      CMD_FETCH: begin
        if (fetch_cl >= clusters) begin
          ans.kind = KIND_NONE;
        end else begin
          len = seg_len[fetch_cl];
          if (fetch_cl == 0) begin
            len += wrap_len;
            if (fetch_pt < wrap_len) idx = seg_start[clusters] + fetch_pt;
            else idx = seg_start[0] + fetch_pt - wrap_len;
          end else begin
            idx = seg_start[fetch_cl] + fetch_pt;
          end
          idx %= MAX_POINTS;
          ans.kind = KIND_POINT;
          ans.number = 5'(fetch_cl);
          ans.wx = 24'(pts_x[idx]);
          ans.wy = 24'(pts_y[idx]);
          if (fetch_pt + 1 >= len) begin
            ans.cend = 1'b1;
            ans.send = (fetch_cl + 1 == clusters);
            fetch_cl++;
            fetch_pt = 0;
          end else begin
            fetch_pt++;
          end
        end
        awaited.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_answer(cur);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        cur = pending.pop_front();
        command <= cur.cmd;
        angle <= cur.ang;
        dist_mm <= cur.dmm;
        pose_x <= cur.px;
        pose_y <= cur.py;
        pose_heading <= cur.hd;
        in_valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall: changing pattern, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      hold_left <= 0;
      hold_done <= 0;
      stall_phase <= 0;
      stall_mode <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_left <= 3000;
      hold_done <= 1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result word with nothing expected: kind %0d", kind);
        failed = 1;
      end else begin
        e = awaited.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind); failed = 1;
        end
        if (cluster_total !== e.total) begin
          $error("cluster_total: expected %0d, got %0d", e.total, cluster_total); failed = 1;
        end
        if (cluster_number !== e.number) begin
          $error("cluster_number: expected %0d, got %0d", e.number, cluster_number); failed = 1;
        end
        if (world_x !== e.wx) begin
          $error("world_x: expected %0d, got %0d", $signed(e.wx), world_x); failed = 1;
        end
        if (world_y !== e.wy) begin
          $error("world_y: expected %0d, got %0d", $signed(e.wy), world_y); failed = 1;
        end
        if (cluster_end !== e.cend) begin
          $error("cluster_end: expected %0d, got %0d", e.cend, cluster_end); failed = 1;
        end
        if (scan_end !== e.send) begin
          $error("scan_end: expected %0d, got %0d", e.send, scan_end); failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic add(cmd_t cm, int a, int d, int x, int y, int h);
    reading_t r;
    r.cmd = cm;
    r.ang = 15'(a);
    r.dmm = 16'(d);
    r.px = 24'(x);
    r.py = 24'(y);
    r.hd = 15'(h);
    pending.push_back(r);
    items_made++;
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    case (idx)
      REG_GAP_THRESHOLD: gap_mm = val & 16'hFFFF;
      REG_MIN_POINTS: min_run = val & 10'h3FF;
      default: range_mm = val & 16'hFFFF;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic settle();
    while (pending.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
    // dropped or loaded readings give no result; let the last one finish
    repeat (60) @(posedge clk);
  endtask

  // one scan of smoothly varying readings, then finish and fetch every point
  task automatic add_scan(int n, int step, int range_hi);
    int a, d, x, y, h;
    a = $urandom_range(0, 23039);
    d = $urandom_range(300, 4000);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 23039);
    case ($urandom_range(0, 7))
      0: begin x = 8388607 - $urandom_range(0, 3000); y = -8388608 + $urandom_range(0, 3000); end
      1: begin x = $urandom; y = $urandom; end
      default: begin x = $urandom_range(0, 2000000) - 1000000;
        y = $urandom_range(0, 2000000) - 1000000; end
    endcase
    for (int i = 0; i < n; i++) begin
      d += int'($urandom_range(0, 40)) - 20;
      if ($urandom_range(0, 11) == 0) d = $urandom_range(300, range_hi);
      if (d < 1) d = 1;
      if (d > 65535) d = 65535;
      case ($urandom_range(0, 39))
        0: add(CMD_LOAD, a, 0, x, y, h);
        1: add(CMD_LOAD, a, $urandom_range(0, 65535), x, y, h);
        2: add(CMD_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: add(CMD_LOAD, a, d, x, y, h);
      endcase
      a = (a + step) % 32768;
    end
    add(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n + 2; i++)
      add(CMD_FETCH, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    failed = 0;
    cycles = 0;
    items_made = 0;
    hold_req = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_GAP_THRESHOLD;
    cfg_data = 0;
    command = CMD_LOAD;
    angle = 0;
    dist_mm = 0;
    pose_x = 0;
    pose_y = 0;
    pose_heading = 0;
    gap_mm = 100;
    min_run = 3;
    range_mm = 12000;
    stored = 0;
    wrap_len = 0;
    clusters = 0;
    fetch_cl = 0;
    fetch_pt = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: empty fetch, drops, extremes, ignored word, a full circle of readings
    add(CMD_FETCH, 0, 0, 0, 0, 0);
    add(CMD_FINISH, 0, 0, 0, 0, 0);
    add(CMD_FETCH, 0, 0, 0, 0, 0);
    add(CMD_LOAD, 100, 0, 0, 0, 0);
    add(CMD_LOAD, 100, 12001, 0, 0, 0);
    add(CMD_LOAD, 32767, 12000, 8388607, -8388608, 32767);
    add(CMD_LOAD, 32767, 12000, 8388607, -8388608, 32767);
    add(CMD_LOAD, 0, 1, -8388608, 8388607, 0);
    add(CMD_IGNORED, 32767, 65535, -1, -1, 32767);
    add(CMD_FINISH, 0, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) add(CMD_FETCH, 0, 0, 0, 0, 0);
    settle();
    write_reg(REG_GAP_THRESHOLD, 200);
    write_reg(REG_MIN_POINTS, 2);
    write_reg(REG_MAX_RANGE, 65535);
    // full circle at constant range forms one run; four far readings then form a second
    for (int i = 0; i < 72; i++) add(CMD_LOAD, i * 320, (i == 36) ? 0 : 1000, 5, -5, 0);
    for (int i = 0; i < 4; i++) add(CMD_LOAD, 3000, 65535, 0, 0, 0);
    add(CMD_FINISH, 0, 0, 0, 0, 0);
    for (int i = 0; i < 80; i++) add(CMD_FETCH, 0, 0, 0, 0, 0);
    settle();

    hold_req <= 1;
    while (items_made < TARGET_ITEMS) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_GAP_THRESHOLD, ($urandom_range(0, 1)) ? 0 : 65535);
        1: write_reg(REG_MIN_POINTS, ($urandom_range(0, 1)) ? 0 : 512);
        2: write_reg(REG_MAX_RANGE, ($urandom_range(0, 1)) ? 1 : 65535);
        default: begin
          write_reg(REG_GAP_THRESHOLD, $urandom_range(20, 400));
          write_reg(REG_MIN_POINTS, $urandom_range(1, 6));
          write_reg(REG_MAX_RANGE, $urandom_range(3000, 20000));
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 19) == 0) add_scan(530, 8, 6000);
        else add_scan($urandom_range(10, 80), $urandom_range(16, 160), 6000);
      end
      settle();
    end

    settle();
    if (failed) $display("testbench: FAIL");
    else $display("testbench: PASS");
    $finish;
  end
endmodule
